@@ rtl/tdf_pkg.sv @@
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared constants and types for the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // Default operand width (bits of the value being factored)
  localparam int unsigned VALUE_WIDTH_DEF = 31;

  // Most results emitted for one request
  localparam int unsigned MAX_RESULTS = 30;

  // First divisor tried, also the smallest prime
  localparam int unsigned FIRST_DIVISOR = 2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EMIT
  } tdf_state_e;

endpackage

@@ rtl/tdf_divider.sv @@
// ----------------------------------------------------------------------------
// tdf_divider
// Restoring divider, one quotient bit per cycle. Gives quotient and remainder
// of an unsigned dividend by a narrower unsigned divisor.
// ----------------------------------------------------------------------------
module tdf_divider #(
  parameter int unsigned DVD_WIDTH = 31,
  parameter int unsigned DVS_WIDTH = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_WIDTH-1:0] dividend_i,
  input  logic [DVS_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [DVD_WIDTH-1:0] quot_o,
  output logic [DVS_WIDTH-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DVD_WIDTH + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DVD_WIDTH-1:0] quot_q, quot_d;
  logic [DVS_WIDTH-1:0] acc_q, acc_d;
  logic [DVS_WIDTH-1:0] dvs_q, dvs_d;

  logic [DVS_WIDTH:0]   acc_sh;
  logic [DVS_WIDTH:0]   acc_diff;
  logic                 acc_ge;

  // Shift in the next dividend bit and try a subtract
  assign acc_sh   = {acc_q, quot_q[DVD_WIDTH-1]};
  assign acc_ge   = acc_sh >= {1'b0, dvs_q};
  assign acc_diff = acc_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DVD_WIDTH);
      quot_d = dividend_i;
      acc_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q - 1'b1;
      quot_d = {quot_q[DVD_WIDTH-2:0], acc_ge};
      acc_d  = acc_ge ? acc_diff[DVS_WIDTH-1:0] : acc_sh[DVS_WIDTH-1:0];
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    acc_q  <= acc_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = acc_q;

endmodule

@@ rtl/trial_division_factorizer.sv @@
// Each divisor tried takes one pass through the shared bit-serial divider;
//   each factor emitted also passes through ST_EMIT.
// One request is taken per search; the worst case is a large prime, which
//   tries every divisor up to about sqrt(value).
// Inputs 0 and 1 skip the divider. s_axis_tready_o is high only when idle.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Emits the prime factors of each request in ascending order by trial
// division, one factor per result, last factor flagged with tlast.
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned TdataW     = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TdataW-1:0] s_axis_tdata_i,   // [VALUE_WIDTH-1:0] value
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,   // [VALUE_WIDTH-1:0] prime_factor
  output logic              m_axis_tlast_o,   // is_last
  output logic              m_axis_tuser_o    // no_factor
);

  // Divisor never exceeds floor(sqrt(value)) + 1
  localparam int unsigned DivW = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned CntW = $clog2(tdf_pkg::MAX_RESULTS);

  tdf_pkg::tdf_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [DivW-1:0]        div_q, div_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] res_factor_q, res_factor_d;
  logic                   res_last_q, res_last_d;
  logic                   res_none_q, res_none_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_factor_q, out_factor_d;
  logic                   out_last_q, out_last_d;
  logic                   out_none_q, out_none_d;

  logic                   in_req;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   out_free;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DivW-1:0]        div_rem;
  logic                   search_end;
  logic                   divisible;
  logic                   at_limit;

  assign in_value   = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_req     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign search_end = VALUE_WIDTH'(div_q) > div_quot;   // divisor^2 > remainder
  assign divisible  = div_rem == '0;
  assign at_limit   = cnt_q == CntW'(tdf_pkg::MAX_RESULTS - 1);

  tdf_divider #(
    .DVD_WIDTH(VALUE_WIDTH),
    .DVS_WIDTH(DivW)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rem_q),
    .divisor_i (div_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdf_pkg::ST_IDLE: begin
        if (in_req) begin
          state_d = (in_value < VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR)) ?
                    tdf_pkg::ST_EMIT : tdf_pkg::ST_START;
        end
      end
      tdf_pkg::ST_START: state_d = tdf_pkg::ST_DIV;
      tdf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (search_end || divisible) ? tdf_pkg::ST_EMIT : tdf_pkg::ST_START;
        end
      end
      tdf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = res_last_q ? tdf_pkg::ST_IDLE : tdf_pkg::ST_START;
        end
      end
      default: state_d = tdf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    rem_d           = rem_q;
    div_d           = div_q;
    cnt_d           = cnt_q;
    res_factor_d    = res_factor_q;
    res_last_d      = res_last_q;
    res_none_d      = res_none_q;
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    out_factor_d    = out_factor_q;
    out_last_d      = out_last_q;
    out_none_d      = out_none_q;
    case (state_q)
      tdf_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_req) begin
          rem_d        = in_value;
          div_d        = DivW'(tdf_pkg::FIRST_DIVISOR);
          cnt_d        = '0;
          res_factor_d = in_value;
          res_last_d   = 1'b1;
          res_none_d   = 1'b1;
        end
      end
      tdf_pkg::ST_START: div_start = 1'b1;
      tdf_pkg::ST_DIV: begin
        if (div_done) begin
          res_none_d = 1'b0;
          if (search_end || (divisible && at_limit)) begin
            // what is left is prime, or the result budget is spent
            res_factor_d = rem_q;
            res_last_d   = 1'b1;
          end else if (divisible) begin
            res_factor_d = VALUE_WIDTH'(div_q);
            res_last_d   = 1'b0;
            rem_d        = div_quot;
            cnt_d        = cnt_q + 1'b1;
          end else begin
            div_d = div_q + 1'b1;
          end
        end
      end
      tdf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_factor_d = res_factor_q;
          out_last_d   = res_last_q;
          out_none_d   = res_none_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    div_q        <= div_d;
    res_factor_q <= res_factor_d;
    res_last_q   <= res_last_d;
    res_none_q   <= res_none_d;
    out_factor_q <= out_factor_d;
    out_last_q   <= out_last_d;
    out_none_q   <= out_none_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TdataW'(out_factor_q);
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_none_q;

endmodule

@@ rtl/tdf_checker.sv @@
// ----------------------------------------------------------------------------
// tdf_checker
// Port-level checks for the trial division factorizer, bound to the top.
// ----------------------------------------------------------------------------
module tdf_checker #(
  parameter int unsigned VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned TdataW     = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic [TdataW-1:0] s_axis_tdata_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [TdataW-1:0] m_axis_tdata_o,
  input logic              m_axis_tlast_o,
  input logic              m_axis_tuser_o
);

  localparam logic [VALUE_WIDTH-1:0] MinPrime = VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // The block is busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after a request");

  // An echoed input below two is always alone, hence last
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tlast_o && (m_axis_tdata_o[VALUE_WIDTH-1:0] < MinPrime))
    else $error("no-factor result malformed");

  // Every real factor is at least two
  a_factor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[VALUE_WIDTH-1:0] >= MinPrime)
    else $error("factor below two");

endmodule

bind trial_division_factorizer tdf_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_tdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
